>>> rtl/byte_budget_lru_cache_assert.svh
// Assertion macros for the byte budget LRU cache.
// Used by modules that check invariants; expects clk and arst_n in scope.
`ifndef BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_ASSERT_SVH

// same-cycle implication, off during reset
`define BLC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/blc_pkg.sv
// Shared types and constants of the byte budget LRU cache.
// No dependencies.
`timescale 1ns / 1ps

package blc_pkg;

	localparam int ENTRIES  = 16;
	localparam int KEY_BITS = 64;
	localparam int IDX_W    = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);

	localparam logic [31:0] CAP_RESET = 32'h1000_0000;

	typedef enum logic [1:0] {
		ACT_GET   = 2'd0,
		ACT_PUT   = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_TRIM  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		OUT_HIT      = 3'd0,
		OUT_MISS     = 3'd1,
		OUT_INSERTED = 3'd2,
		OUT_UPDATED  = 3'd3,
		OUT_DROPPED  = 3'd4,
		OUT_CLEARED  = 3'd5,
		OUT_TRIMMED  = 3'd6
	} outcome_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [31:0] value_handle;
		logic [31:0] entry_bytes;
	} req_t;

	typedef struct packed {
		logic [2:0]  outcome;
		logic [31:0] hit_value;
		logic [4:0]  evicted_count;
		logic [4:0]  entry_count;
		logic [31:0] bytes_used;
		logic [31:0] hit_total;
		logic [31:0] miss_total;
	} rsp_t;

	// per-slot payload held in the slot RAM
	typedef struct packed {
		logic [31:0] value;
		logic [31:0] bytes;
	} slot_t;

	// tag array update, one at a time
	typedef struct packed {
		logic                clr_all;
		logic                set;
		logic                inv;
		logic [IDX_W-1:0]    idx;
		logic [KEY_BITS-1:0] key;
	} tag_op_t;

	typedef logic [ENTRIES-1:0][IDX_W-1:0] order_arr_t;

endpackage

>>> rtl/blc_slot_ram.sv
// Slot payload RAM: value handle and byte size per slot.
// One write port, one read port, registered read. Uses blc_pkg.
`timescale 1ns / 1ps

module blc_slot_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [blc_pkg::IDX_W-1:0] waddr,
	input  blc_pkg::slot_t            wdata,
	input  logic                      re,
	input  logic [blc_pkg::IDX_W-1:0] raddr,
	output blc_pkg::slot_t            rdata
);
	import blc_pkg::*;

	slot_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/blc_tag_cam.sv
// Key tags and valid bits with a parallel compare per slot.
// Uses blc_pkg.
`timescale 1ns / 1ps

module blc_tag_cam (
	input  logic                         clk,
	input  logic                         arst_n,
	input  blc_pkg::tag_op_t             op,
	input  logic [blc_pkg::KEY_BITS-1:0] cmp_key,
	output logic [blc_pkg::ENTRIES-1:0]  match,
	output logic [blc_pkg::ENTRIES-1:0]  valid
);
	import blc_pkg::*;

	logic [KEY_BITS-1:0] tag_q [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (op.clr_all) begin
			valid_q <= '0;
		end else if (op.set) begin
			valid_q[op.idx] <= 1'b1;
		end else if (op.inv) begin
			valid_q[op.idx] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op.set) begin
			tag_q[op.idx] <= op.key;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == cmp_key);
		end
	end

	assign valid = valid_q;

endmodule

>>> rtl/byte_budget_lru_cache.sv
// Byte budget LRU cache, top level. Uses blc_pkg, blc_tag_cam, blc_slot_ram.
// Path: get hit LOOK, READ, APPLY, DONE; get miss, clear and drop LOOK, DONE; each eviction
// adds an EVRD, EVWB pass. Throughput: one request at a time; next request taken once the
// result is registered and the output register accepts it; the eviction loop sets the spread.
// Reset: arst_n async low; cache empty, counters zero, capacity 0x1000_0000.
`timescale 1ns / 1ps

`include "byte_budget_lru_cache_assert.svh"

module byte_budget_lru_cache (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  blc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output blc_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [31:0]   cfg_wdata
);
	import blc_pkg::*;

	// one-hot sequencer
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_LOOK  = 8'b0000_0010, // tag compare
		ST_READ  = 8'b0000_0100, // RAM read of hit slot, find its position
		ST_APPLY = 8'b0000_1000, // use RAM data of hit slot, rewrite it on a put
		ST_EVRD  = 8'b0001_0000, // decide eviction, read LRU slot size
		ST_EVWB  = 8'b0010_0000, // retire LRU slot
		ST_INS   = 8'b0100_0000, // insert new entry
		ST_DONE  = 8'b1000_0000  // hand result to output register
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [IDX_W-1:0]    hit_slot_q;
	logic [IDX_W-1:0]    lru_slot_q;
	logic [IDX_W-1:0]    pos_q;
	logic                ins_mode_q;  // eviction rule of a new-key put
	outcome_t            outcome_q;
	logic [31:0]         hit_value_q;
	logic [CNT_W-1:0]    evict_q;
	logic [CNT_W-1:0]    held_q;
	logic [32:0]         used_q;      // extra bit covers update overshoot
	logic [31:0]         hit_cnt_q;
	logic [31:0]         miss_cnt_q;
	logic [31:0]         cap_q;
	order_arr_t          order_q;     // position 0 = most recent
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	tag_op_t             tag_op;
	logic [ENTRIES-1:0]  match;
	logic [ENTRIES-1:0]  valid_vec;
	logic                hit_c;
	logic [IDX_W-1:0]    hit_slot_c;
	logic [IDX_W-1:0]    pos_c;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	slot_t               ram_wdata;
	logic                ram_re;
	logic [IDX_W-1:0]    ram_raddr;
	slot_t               ram_rdata;
	logic                over_c;
	logic                evict_c;
	logic [IDX_W-1:0]    lru_slot_c;
	logic [IDX_W-1:0]    ins_slot_c;
	logic                rsp_load;

	// move position p to the front, shifting the newer ones back by one
	function automatic order_arr_t promote(input order_arr_t o, input logic [IDX_W-1:0] p);
		order_arr_t r;
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == 0) begin
				r[i] = o[p];
			end else if (IDX_W'(i) <= p) begin
				r[i] = o[i-1];
			end else begin
				r[i] = o[i];
			end
		end
		return r;
	endfunction

	blc_tag_cam u_tag (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (tag_op),
		.cmp_key (req_q.key[KEY_BITS-1:0]),
		.match   (match),
		.valid   (valid_vec)
	);

	blc_slot_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// keys are unique, so the match vector is one-hot or empty
	always_comb begin
		hit_c      = |match;
		hit_slot_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match[i]) begin
				hit_slot_c = IDX_W'(i);
			end
		end
	end

	// recency position of the hit slot
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (order_q[i] == hit_slot_q && CNT_W'(i) < held_q) begin
				pos_c = IDX_W'(i);
			end
		end
	end

	// eviction test: new-key put needs room for its bytes and a free slot; else bytes used must fit
	always_comb begin
		if (ins_mode_q) begin
			over_c = ({1'b0, used_q} + 34'(req_q.entry_bytes)) > 34'(cap_q);
		end else begin
			over_c = used_q > 33'(cap_q);
		end
		evict_c = (held_q != '0) &&
			(over_c || (ins_mode_q && held_q == CNT_W'(ENTRIES)));
		lru_slot_c = order_q[IDX_W'(held_q - CNT_W'(1))];
		ins_slot_c = order_q[held_q[IDX_W-1:0]];
	end

	// tag and RAM control
	always_comb begin
		tag_op         = '0;
		tag_op.key     = req_q.key[KEY_BITS-1:0];
		ram_we         = 1'b0;
		ram_waddr      = hit_slot_q;
		ram_wdata.value = req_q.value_handle;
		ram_wdata.bytes = req_q.entry_bytes;
		ram_re         = 1'b0;
		ram_raddr      = hit_slot_q;
		unique case (state_q)
			ST_LOOK: begin
				tag_op.clr_all = (req_q.action == ACT_CLEAR);
			end
			ST_READ: begin
				ram_re = 1'b1;
			end
			ST_APPLY: begin
				ram_we = (req_q.action == ACT_PUT);
			end
			ST_EVRD: begin
				ram_re    = evict_c;
				ram_raddr = lru_slot_c;
			end
			ST_EVWB: begin
				tag_op.inv = 1'b1;
				tag_op.idx = lru_slot_q;
			end
			ST_INS: begin
				tag_op.set = 1'b1;
				tag_op.idx = ins_slot_c;
				ram_we     = 1'b1;
				ram_waddr  = ins_slot_c;
			end
			default: begin
			end
		endcase
	end

	assign req_ready = (state_q == ST_IDLE);
	// output register frees up the core while a result waits downstream
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// capacity register; a zero write is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we && cfg_wdata != '0) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.outcome       <= outcome_q;
			rsp_q.hit_value     <= hit_value_q;
			rsp_q.evicted_count <= 5'(evict_q);
			rsp_q.entry_count   <= 5'(held_q);
			rsp_q.bytes_used    <= used_q[31:0];
			rsp_q.hit_total     <= hit_cnt_q;
			rsp_q.miss_total    <= miss_cnt_q;
		end
	end

	// request-local working registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (state_q == ST_LOOK) begin
			hit_slot_q <= hit_slot_c;
		end
		if (state_q == ST_READ) begin
			pos_q <= pos_c;
		end
		if (state_q == ST_EVRD) begin
			lru_slot_q <= lru_slot_c;
		end
	end

	// sequencer and cache state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ins_mode_q  <= 1'b0;
			outcome_q   <= OUT_HIT;
			hit_value_q <= '0;
			evict_q     <= '0;
			held_q      <= '0;
			used_q      <= '0;
			hit_cnt_q   <= '0;
			miss_cnt_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				order_q[i] <= IDX_W'(i);
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_value_q <= '0;
					evict_q     <= '0;
					ins_mode_q  <= 1'b0;
					case (req_q.action)
						ACT_GET: begin
							if (hit_c) begin
								state_q <= ST_READ;
							end else begin
								if (miss_cnt_q != '1) begin
									miss_cnt_q <= miss_cnt_q + 32'd1;
								end
								outcome_q <= OUT_MISS;
								state_q   <= ST_DONE;
							end
						end
						ACT_PUT: begin
							if (req_q.value_handle == '0) begin
								outcome_q <= OUT_DROPPED;
								state_q   <= ST_DONE;
							end else if (hit_c) begin
								state_q <= ST_READ;
							end else if (req_q.entry_bytes > cap_q) begin
								outcome_q <= OUT_DROPPED;
								state_q   <= ST_DONE;
							end else begin
								ins_mode_q <= 1'b1;
								outcome_q  <= OUT_INSERTED;
								state_q    <= ST_EVRD;
							end
						end
						ACT_CLEAR: begin
							held_q     <= '0;
							used_q     <= '0;
							hit_cnt_q  <= '0;
							miss_cnt_q <= '0;
							outcome_q  <= OUT_CLEARED;
							state_q    <= ST_DONE;
						end
						default: begin
							outcome_q <= OUT_TRIMMED;
							state_q   <= ST_EVRD;
						end
					endcase
				end
				ST_READ: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					order_q <= promote(order_q, pos_q);
					if (req_q.action == ACT_PUT) begin
						used_q    <= used_q - 33'(ram_rdata.bytes) + 33'(req_q.entry_bytes);
						outcome_q <= OUT_UPDATED;
						state_q   <= ST_EVRD;
					end else begin
						if (hit_cnt_q != '1) begin
							hit_cnt_q <= hit_cnt_q + 32'd1;
						end
						hit_value_q <= ram_rdata.value;
						outcome_q   <= OUT_HIT;
						state_q     <= ST_DONE;
					end
				end
				ST_EVRD: begin
					if (evict_c) begin
						state_q <= ST_EVWB;
					end else if (ins_mode_q) begin
						state_q <= ST_INS;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_EVWB: begin
					used_q  <= used_q - 33'(ram_rdata.bytes);
					held_q  <= held_q - CNT_W'(1);
					evict_q <= evict_q + CNT_W'(1);
					state_q <= ST_EVRD;
				end
				ST_INS: begin
					order_q <= promote(order_q, held_q[IDX_W-1:0]);
					held_q  <= held_q + CNT_W'(1);
					used_q  <= used_q + 33'(req_q.entry_bytes);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`BLC_ASSERT(a_held_max, 1'b1, held_q <= CNT_W'(ENTRIES), "entry count above slot count")
	`BLC_ASSERT(a_used_fits, state_q == ST_IDLE, used_q[32] == 1'b0, "bytes used overflow at rest")
	`BLC_ASSERT(a_valid_count, state_q == ST_IDLE,
		CNT_W'($countones(valid_vec)) == held_q, "valid bits disagree with entry count")
	`BLC_ASSERT_NEXT(a_evict_step, state_q == ST_EVWB,
		held_q == $past(held_q) - CNT_W'(1), "eviction did not retire one entry")

endmodule
